// File: src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types and constants for the utf-8 to utf-16 stream decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int ByteW  = 8;
  localparam int UnitW  = 16;
  localparam int CodeW  = 21;

  typedef logic [CodeW-1:0] code_point_t;
  typedef logic [UnitW-1:0] unit_t;

  localparam code_point_t CodeLimit = 21'h110000;
  localparam code_point_t PlaneOne  = 21'h010000;

  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;

  // completed code point request between decode and emit
  typedef struct packed {
    logic        valid;
    code_point_t code;
  } cp_req_t;

endpackage

// File: src/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// tracks the pending continuation count and the code point accumulator,
// registers each completed code point below the unicode limit
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output u8d_pkg::cp_req_t    cp_req,
  input  logic                cp_ready
);
  import u8d_pkg::*;

  logic [1:0]  bytes_pending, bytes_pending_next;
  code_point_t code_accum, code_accum_next;
  logic        cp_valid;
  code_point_t cp_code;
  logic        done;
  logic        in_fire;

  assign in_ready = !cp_valid || cp_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    done               = 1'b0;
    if (bytes_pending == 2'd0) begin
      if (in_byte inside {[8'h00:8'h7F]}) begin
        code_accum_next = {13'd0, in_byte};
        done            = 1'b1;
      end else if (in_byte inside {[8'hC0:8'hDF]}) begin
        bytes_pending_next = 2'd1;
        code_accum_next    = {16'd0, in_byte[4:0]};
      end else if (in_byte inside {[8'hE0:8'hEF]}) begin
        bytes_pending_next = 2'd2;
        code_accum_next    = {17'd0, in_byte[3:0]};
      end else if (in_byte inside {[8'hF0:8'hF7]}) begin
        bytes_pending_next = 2'd3;
        code_accum_next    = {18'd0, in_byte[2:0]};
      end
    end else if (in_byte inside {[8'h80:8'hBF]}) begin
      code_accum_next    = {code_accum[CodeW-7:0], in_byte[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
      done               = (bytes_pending == 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      code_accum    <= '0;
      cp_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        bytes_pending <= bytes_pending_next;
        code_accum    <= code_accum_next;
      end
      if (in_ready) begin
        // values at or above the limit complete silently
        cp_valid <= in_fire && done && (code_accum_next < CodeLimit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      cp_code <= code_accum_next;
    end
  end

  assign cp_req.valid = cp_valid;
  assign cp_req.code  = cp_code;

`ifndef SYNTHESIS
  a_cp_in_range: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> cp_code < CodeLimit)
    else $error("code point beyond limit");

  a_stray_ignored: assert property (@(posedge clk) disable iff (rst)
    (in_fire && bytes_pending != 2'd0 && in_byte[7:6] != 2'b10)
      |=> ($stable(bytes_pending) && $stable(code_accum)))
    else $error("non-continuation byte changed state");

  a_cp_held: assert property (@(posedge clk) disable iff (rst)
    (cp_valid && !cp_ready) |=> (cp_valid && $stable(cp_code)))
    else $error("code point dropped while stalled");
`endif

endmodule

// File: src/u8d_emit.sv
// ----------------------------------------------------------------------------
// u8d_emit
// turns a code point into one utf-16 unit or a surrogate pair, with an
// output register and a second-unit holding register
// ----------------------------------------------------------------------------
module u8d_emit (
  input  logic                clk,
  input  logic                rst,
  input  u8d_pkg::cp_req_t    cp_req,
  output logic                cp_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output u8d_pkg::unit_t      out_unit,
  output logic                out_last
);
  import u8d_pkg::*;

  logic        second_valid;
  unit_t       second_unit;
  logic        out_fire;
  code_point_t offset;
  logic        pair;
  unit_t       high_unit, low_unit;

  assign out_fire = out_valid && out_ready;
  assign cp_ready = !second_valid && (!out_valid || out_ready);

  assign offset    = cp_req.code - PlaneOne;
  assign pair      = (cp_req.code >= PlaneOne);
  assign high_unit = {HighTag, offset[19:10]};
  assign low_unit  = {LowTag, offset[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      second_valid <= 1'b0;
    end else if (second_valid) begin
      if (out_fire) begin
        second_valid <= 1'b0;
      end
    end else if (cp_ready) begin
      out_valid    <= cp_req.valid;
      second_valid <= cp_req.valid && pair;
    end
  end

  always_ff @(posedge clk) begin
    if (second_valid) begin
      if (out_fire) begin
        out_unit <= second_unit;
        out_last <= 1'b1;
      end
    end else if (cp_ready) begin
      out_unit    <= pair ? high_unit : cp_req.code[UnitW-1:0];
      out_last    <= !pair;
      second_unit <= low_unit;
    end
  end

`ifndef SYNTHESIS
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    second_valid |-> (out_valid && !out_last))
    else $error("second unit without first");

  a_high_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_unit[15:10] == HighTag && second_valid))
    else $error("non-final unit is not a high surrogate");

  a_low_tag: assert property (@(posedge clk) disable iff (rst)
    second_valid |-> (second_unit[15:10] == LowTag))
    else $error("held unit is not a low surrogate");
`endif

endmodule

// File: src/utf8_to_utf16_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// decodes a utf-8 byte stream into utf-16 code units
//
//   channel   dir   fields                       per request
//   s_axis    in    tdata[7:0] byte              one utf-8 byte
//   m_axis    out   tdata[15:0] unit, tlast      one utf-16 unit
//
// one byte accepted per cycle while s_axis_tready is high; a completed code point
// is registered in the decode register, then in the emit register
// a surrogate pair leaves the emit register as the high unit, then the low unit
// reset clears the pending count, accumulator and all valid flags
// a stalled output holds the emit register, then the decode register,
// then s_axis_tready drops
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] utf16_unit
  output logic        m_axis_tlast
);
  import u8d_pkg::*;

  cp_req_t cp_req;
  logic    cp_ready;

  u8d_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .cp_req   (cp_req),
    .cp_ready (cp_ready)
  );

  u8d_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cp_req    (cp_req),
    .cp_ready  (cp_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_unit  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: test/utf16_unit_checker.sv
// ----------------------------------------------------------------------------
// utf16_unit_checker
// watches both stream channels of the utf-8 to utf-16 decoder, decodes every
// accepted byte on its own and compares each delivered unit and its last
// flag against the oldest predicted unit
// ----------------------------------------------------------------------------
module utf16_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [15:0] utf16_unit
  input  logic        m_axis_tlast,
  output int          errors,
  output int          outstanding
);
  import u8d_pkg::*;

  typedef struct packed {
    unit_t unit;
    logic  last;
  } unit_req_t;

  unit_req_t   unit_q[$];
  unit_req_t   expd;
  logic [1:0]  cont_left;
  code_point_t code_acc;

  task automatic queue_code_point(input code_point_t cp);
    code_point_t off;
    if (cp < PlaneOne) begin
      unit_q.push_back('{cp[15:0], 1'b1});
    end else if (cp < CodeLimit) begin
      off = cp - PlaneOne;
      unit_q.push_back('{{HighTag, off[19:10]}, 1'b0});
      unit_q.push_back('{{LowTag, off[9:0]}, 1'b1});
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        code_acc = {13'd0, b};
        queue_code_point(code_acc);
      end else if (b[7:5] == 3'b110) begin
        cont_left = 2'd1;
        code_acc  = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        cont_left = 2'd2;
        code_acc  = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        cont_left = 2'd3;
        code_acc  = {18'd0, b[2:0]};
      end
    end else if (b[7:6] == 2'b10) begin
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) queue_code_point(code_acc);
    end
  endtask

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cont_left = 2'd0;
      code_acc  = '0;
      unit_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (unit_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected unit, expected none, actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          expd = unit_q.pop_front();
          if (expd.unit !== m_axis_tdata || expd.last !== m_axis_tlast) begin
            errors++;
            $display("%0t: unit mismatch, expected %h last %b, actual %h last %b",
                     $time, expd.unit, expd.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
    end
    outstanding = unit_q.size();
  end

endmodule

// File: test/utf8_to_utf16_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_tb
// drives the decoder with directed utf-8 byte runs, then mostly well-formed
// random sequences mixed with stray and truncated bytes, under random idling
// on both channels and one long output hold-off; checking is done by a
// separate unit checker
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_tb;

  localparam int NumItems      = 1350;
  localparam int CycleLimit    = 1000000;
  localparam int DrainCycles   = 20;
  localparam int HoldOffCycles = 200;
  localparam int HoldOffStart  = 600;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] utf16_unit
  logic        m_axis_tlast;
  logic        draining;
  int          errors;
  int          outstanding;
  int          cycles;
  int          sent;

  utf8_to_utf16_stream_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  utf16_unit_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // called at a falling edge, returns at the falling edge after the request
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = ((sent / 50) % 4 == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_sequence();
    int r;
    int len;
    int n;
    r = $urandom_range(99);
    if (r < 12) begin
      // stray bytes of any value
      n = $urandom_range(3, 1);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (r < 18) begin
      // truncated sequence, the next lead byte lands while still pending
      len = $urandom_range(4, 2);
      send_byte(lead_byte(len));
      n = $urandom_range(len - 2, 0);
      repeat (n) send_byte(cont_byte());
    end else begin
      len = $urandom_range(4, 1);
      send_byte(lead_byte(len));
      repeat (len - 1) send_byte(cont_byte());
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    directed = '{8'h00, 8'h7F,
                 8'hC2, 8'h80, 8'hDF, 8'hBF,
                 8'hEF, 8'hBF, 8'hBF,
                 8'hF0, 8'h90, 8'h80, 8'h80,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'hF4, 8'h90, 8'h80, 8'h80,
                 8'h80, 8'hFF,
                 8'hC3, 8'h41, 8'hA9};
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    draining      = 1'b0;
    sent          = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) send_byte(directed[i]);
    while (sent < NumItems) send_sequence();
    s_axis_tvalid <= 1'b0;
    draining      <= 1'b1;
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int  run;
    int  waited;
    int  r;
    bit  held;
    m_axis_tready = 1'b0;
    waited        = 0;
    held          = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && !draining && waited > HoldOffStart) begin
        // long hold-off so the decoder fills and stalls its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        run = HoldOffCycles;
      end else begin
        r = $urandom_range(99);
        if (draining || (waited / 500) % 4 == 1 || r < 60) begin
          m_axis_tready <= 1'b1;
          run = $urandom_range(20, 1);
        end else if (r < 92) begin
          m_axis_tready <= 1'b0;
          run = $urandom_range(3, 1);
        end else begin
          m_axis_tready <= 1'b0;
          run = $urandom_range(50, 10);
        end
      end
      while (run > 0) begin
        @(negedge clk);
        waited++;
        run = (draining && !m_axis_tready) ? 0 : run - 1;
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
